FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a plain condition on every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Concurrent check of an implication on every clock edge out of reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: src/lpp_pkg.sv
`timescale 1ns / 1ps

package lpp_pkg;

    localparam int unsigned MAX_BUFFER_BYTES = 65536;
    localparam int unsigned MAX_PARAMS       = 255;
    localparam int unsigned CAP_INT          =
        (MAX_BUFFER_BYTES > 65535) ? 65535 : MAX_BUFFER_BYTES;
    localparam logic [15:0] CONSUMED_CAP     = 16'(CAP_INT);
    localparam logic [31:0] MAX_PARAMS_W     = 32'(MAX_PARAMS);

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN     = 2'd1;

    localparam int unsigned OUT_TDATA_W = 72;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] expected_count;
        logic       big_endian;
    } t_cfg;

    typedef struct packed {
        logic        item_vld;
        t_kind       item_kind;
        logic [7:0]  item_idx;
        logic [31:0] item_val;
        logic        sum_vld;
        logic [7:0]  sum_params;
        logic [15:0] sum_consumed;
        logic        sum_ok;
    } t_evt;

endpackage

FILE: src/lpp_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lpp_pkg::t_cfg i_cfg,
    input  logic          i_tvalid,
    output logic          o_tready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    input  logic          i_q_full,
    output logic          o_evt_push,
    output lpp_pkg::t_evt o_evt
);
    import lpp_pkg::*;

    typedef enum logic [1:0] {
        PH_COUNT,
        PH_LEN,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_pos, n_pos;
    logic [31:0] r_shift, n_shift;
    logic [7:0]  r_param, n_param;
    logic [31:0] r_left, n_left;
    logic [15:0] r_consumed, n_consumed;

    logic        w_accept;
    logic [31:0] w_word;
    t_evt        w_evt;

    function automatic logic [15:0] f_sat_add(input logic [15:0] a, input logic [2:0] n);
        logic [16:0] s;
        s = {1'b0, a} + {14'd0, n};
        return (s > {1'b0, CONSUMED_CAP}) ? CONSUMED_CAP : s[15:0];
    endfunction

    assign w_accept   = i_tvalid && !i_q_full;
    assign o_tready   = !i_q_full;
    assign o_evt      = w_evt;
    assign o_evt_push = w_accept && (w_evt.item_vld || w_evt.sum_vld);

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_shift    = r_shift;
        n_param    = r_param;
        n_left     = r_left;
        n_consumed = r_consumed;
        w_evt      = '0;
        w_word     = '0;

        case (r_phase)
            PH_COUNT, PH_LEN: begin
                if (i_cfg.big_endian) begin
                    w_word = {r_shift[23:0], i_data_byte};
                end else begin
                    w_word = r_shift | ({24'd0, i_data_byte} << {r_pos, 3'b000});
                end
                n_pos   = r_pos + 2'd1;
                n_shift = w_word;
                if (r_pos == 2'd3) begin
                    n_shift = '0;
                    if (r_phase == PH_COUNT) begin
                        if (w_word == {24'd0, i_cfg.expected_count} &&
                            w_word <= MAX_PARAMS_W) begin
                            n_consumed = f_sat_add(r_consumed, 3'd4);
                            n_phase = (i_cfg.expected_count == 8'd0) ? PH_DONE : PH_LEN;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end else begin
                        w_evt.item_vld  = 1'b1;
                        w_evt.item_kind = KIND_HEADER;
                        w_evt.item_idx  = r_param;
                        w_evt.item_val  = w_word;
                        n_param    = r_param + 8'd1;
                        n_consumed = f_sat_add(r_consumed, 3'd4);
                        if (w_word == 32'd0) begin
                            n_phase = (n_param >= i_cfg.expected_count) ? PH_DONE : PH_LEN;
                        end else begin
                            n_left  = w_word;
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                w_evt.item_vld  = 1'b1;
                w_evt.item_kind = KIND_PAYLOAD;
                w_evt.item_idx  = r_param - 8'd1;
                w_evt.item_val  = {24'd0, i_data_byte};
                n_consumed = f_sat_add(r_consumed, 3'd1);
                n_left     = r_left - 32'd1;
                if (n_left == 32'd0) begin
                    n_phase = (r_param >= i_cfg.expected_count) ? PH_DONE : PH_LEN;
                end
            end
            default: begin
            end
        endcase

        if (i_last_byte) begin
            w_evt.sum_vld      = 1'b1;
            w_evt.sum_params   = n_param;
            w_evt.sum_consumed = n_consumed;
            w_evt.sum_ok       = (n_param == i_cfg.expected_count) &&
                                 (i_cfg.expected_count == 8'd0 || n_phase != PH_PAYLOAD);
            n_phase    = PH_COUNT;
            n_pos      = '0;
            n_shift    = '0;
            n_param    = '0;
            n_left     = '0;
            n_consumed = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_COUNT;
            r_pos      <= '0;
            r_shift    <= '0;
            r_param    <= '0;
            r_left     <= '0;
            r_consumed <= '0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_shift    <= n_shift;
            r_param    <= n_param;
            r_left     <= n_left;
            r_consumed <= n_consumed;
        end
    end

    `ASSERT_IMPL(a_word_pos_phase, r_pos != 2'd0,
        r_phase == PH_COUNT || r_phase == PH_LEN, "partial word outside word phases")
    `ASSERT_IMPL(a_payload_left, r_phase == PH_PAYLOAD, r_left != 32'd0,
        "payload phase with nothing left")
    `ASSERT_IMPL(a_push_room, o_evt_push, !i_q_full, "event pushed into full queue")

endmodule

FILE: src/lpp_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lpp_pkg::t_evt i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output lpp_pkg::t_evt o_data
);
    import lpp_pkg::*;

    t_evt                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_count_range, r_count <= (QUEUE_AW + 1)'(QUEUE_DEPTH),
        "queue count out of range")
    `ASSERT_IMPL(a_no_overflow, i_push, !o_full, "push into full queue")
    `ASSERT_IMPL(a_no_underflow, i_pop, !o_empty, "pop from empty queue")

endmodule

FILE: src/lpp_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpp_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_empty,
    input  lpp_pkg::t_evt                    i_q_data,
    output logic                             o_q_pop,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    output logic [lpp_pkg::OUT_TDATA_W-1:0]  o_tdata,
    output logic [1:0]                       o_tuser,
    output logic                             o_tlast
);
    import lpp_pkg::*;

    logic        r_vld, n_vld;
    t_kind       r_kind, n_kind;
    logic [7:0]  r_idx, n_idx;
    logic [31:0] r_val, n_val;
    logic [7:0]  r_params, n_params;
    logic [15:0] r_consumed, n_consumed;
    logic        r_ok, n_ok;
    logic        r_last, n_last;
    logic        r_pend, n_pend;
    t_evt        r_pend_evt, n_pend_evt;

    logic        w_load;

    assign w_load = !r_vld || i_tready;

    always_comb begin
        n_vld      = r_vld;
        n_kind     = r_kind;
        n_idx      = r_idx;
        n_val      = r_val;
        n_params   = r_params;
        n_consumed = r_consumed;
        n_ok       = r_ok;
        n_last     = r_last;
        n_pend     = r_pend;
        n_pend_evt = r_pend_evt;
        o_q_pop    = 1'b0;

        if (w_load) begin
            n_vld = 1'b0;
            if (r_pend) begin
                n_vld      = 1'b1;
                n_kind     = KIND_SUMMARY;
                n_idx      = '0;
                n_val      = '0;
                n_params   = r_pend_evt.sum_params;
                n_consumed = r_pend_evt.sum_consumed;
                n_ok       = r_pend_evt.sum_ok;
                n_last     = 1'b1;
                n_pend     = 1'b0;
            end else if (!i_q_empty) begin
                o_q_pop = 1'b1;
                n_vld   = 1'b1;
                if (i_q_data.item_vld) begin
                    n_kind     = i_q_data.item_kind;
                    n_idx      = i_q_data.item_idx;
                    n_val      = i_q_data.item_val;
                    n_params   = '0;
                    n_consumed = '0;
                    n_ok       = 1'b0;
                    n_last     = !i_q_data.sum_vld;
                    n_pend     = i_q_data.sum_vld;
                    n_pend_evt = i_q_data;
                end else begin
                    n_kind     = KIND_SUMMARY;
                    n_idx      = '0;
                    n_val      = '0;
                    n_params   = i_q_data.sum_params;
                    n_consumed = i_q_data.sum_consumed;
                    n_ok       = i_q_data.sum_ok;
                    n_last     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_vld  <= n_vld;
            r_pend <= n_pend;
        end
        r_kind     <= n_kind;
        r_idx      <= n_idx;
        r_val      <= n_val;
        r_params   <= n_params;
        r_consumed <= n_consumed;
        r_ok       <= n_ok;
        r_last     <= n_last;
        r_pend_evt <= n_pend_evt;
    end

    assign o_tvalid = r_vld;
    assign o_tuser  = r_kind;
    assign o_tlast  = r_last;
    assign o_tdata  = {7'd0, r_ok, r_consumed, r_params, r_val, r_idx};

    `ASSERT_IMPL(a_pend_has_item, r_pend, r_vld, "pending summary without item in output")
    `ASSERT_IMPL(a_summary_last, r_vld && r_kind == KIND_SUMMARY, r_last,
        "summary not marked last")
    `ASSERT_IMPL(a_pend_not_last, r_pend, !r_last, "item marked last with summary pending")

endmodule

FILE: src/length_prefixed_param_parser_core.sv
// Path: a result reaches o_m_tvalid through the event queue and then the output register.
// Throughput: one byte per cycle while the event queue is not full; each result leaves as a
// transfer of its own, so a byte causing a result and the end summary makes two transfers,
// with a four-entry event queue between parser and output stage absorbing the backlog.
// Reset: i_rst_n synchronous active low; clears parse state, config, output valid/pending and the queue.
`timescale 1ns / 1ps

module length_prefixed_param_parser_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [7:0]                          i_s_tdata,   // [7:0] data_byte
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [7:0] param_index, [39:8] value, [47:40] params_read,
    // [63:48] consumed_bytes, [64] ok, [71:65] zero
    output logic [lpp_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic [1:0]                          o_m_tuser,   // [1:0] kind
    output logic                                o_m_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lpp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [7:0]                          i_cfg_data
);
    import lpp_pkg::*;

    t_cfg r_cfg;
    t_evt w_evt_in, w_evt_out;
    logic w_push, w_pop, w_full, w_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_EXPECTED_COUNT: r_cfg.expected_count <= i_cfg_data;
                REG_BIG_ENDIAN:     r_cfg.big_endian     <= i_cfg_data[0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    lpp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_tvalid    (i_s_tvalid),
        .o_tready    (o_s_tready),
        .i_data_byte (i_s_tdata),
        .i_last_byte (i_s_tlast),
        .i_q_full    (w_full),
        .o_evt_push  (w_push),
        .o_evt       (w_evt_in)
    );

    lpp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_evt_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_evt_out)
    );

    lpp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_q_data  (w_evt_out),
        .o_q_pop   (w_pop),
        .o_tvalid  (o_m_tvalid),
        .i_tready  (i_m_tready),
        .o_tdata   (o_m_tdata),
        .o_tuser   (o_m_tuser),
        .o_tlast   (o_m_tlast)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lpp_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 5000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASE_BYTES  = 100;
    localparam int unsigned NUM_PHASES   = 8;
    localparam int unsigned LONG_PAYLOAD = 200;

    typedef enum logic [1:0] {
        PS_COUNT,
        PS_LEN,
        PS_PAYLOAD,
        PS_DONE
    } t_parse_state;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  idx;
        logic [31:0] val;
        logic [7:0]  nread;
        logic [15:0] nbytes;
        logic        ok;
        logic        lst;
    } t_result;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [7:0]           data;
        logic                 last;
        logic                 chk;
        logic [7:0]           nread;
        logic [15:0]          nbytes;
        logic                 ok;
    } t_step;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [7:0]             i_s_tdata;
    logic                   i_s_tlast;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [1:0]             o_m_tuser;
    logic                   o_m_tlast;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [7:0]             i_cfg_data;

    length_prefixed_param_parser_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow registers and parse state of the predictor
    logic [7:0]   exp_cnt   = '0;
    logic         big_end   = 1'b0;
    t_parse_state ps        = PS_COUNT;
    logic [1:0]   wpos      = '0;
    logic [31:0]  wacc      = '0;
    logic [7:0]   pidx      = '0;
    logic [31:0]  remain    = '0;
    logic [15:0]  nconsumed = '0;

    t_result    result_q[$];
    logic [8:0] pending_q[$];
    t_step      steps[$];

    int  n_errors     = 0;
    int  n_checked    = 0;
    int  items_sent   = 0;
    int  buffers_sent = 0;
    int  reg_writes   = 0;
    int  idle_cycles  = 0;
    bit  quiet        = 1'b0;
    bit  hold_off_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic add_bytes(input int unsigned k);
        int unsigned s;
        s = int'(nconsumed) + k;
        nconsumed = (s > int'(CONSUMED_CAP)) ? CONSUMED_CAP : 16'(s);
    endtask

    task automatic restart_parse();
        ps        = PS_COUNT;
        wpos      = '0;
        wacc      = '0;
        pidx      = '0;
        remain    = '0;
        nconsumed = '0;
    endtask

    // Predict the results of one accepted byte and queue them
    task automatic parse_byte(input logic [7:0] b, input logic lb);
        t_result item;
        t_result summ;
        bit      have_item;
        logic    trunc;
        logic [31:0] w;
        item      = '0;
        summ      = '0;
        have_item = 1'b0;
        if (ps == PS_COUNT || ps == PS_LEN) begin
            if (big_end) begin
                wacc = {wacc[23:0], b};
            end else begin
                wacc = wacc | (32'(b) << (8 * wpos));
            end
            wpos = wpos + 2'd1;
            if (wpos == 2'd0) begin
                w    = wacc;
                wacc = '0;
                if (ps == PS_COUNT) begin
                    if (w == {24'd0, exp_cnt} && w <= MAX_PARAMS_W) begin
                        add_bytes(4);
                        ps = (exp_cnt == 8'd0) ? PS_DONE : PS_LEN;
                    end else begin
                        ps = PS_DONE;
                    end
                end else begin
                    item.kind = KIND_HEADER;
                    item.idx  = pidx;
                    item.val  = w;
                    have_item = 1'b1;
                    pidx      = pidx + 8'd1;
                    add_bytes(4);
                    if (w == 32'd0) begin
                        ps = (pidx >= exp_cnt) ? PS_DONE : PS_LEN;
                    end else begin
                        remain = w;
                        ps     = PS_PAYLOAD;
                    end
                end
            end
        end else if (ps == PS_PAYLOAD) begin
            item.kind = KIND_PAYLOAD;
            item.idx  = pidx - 8'd1;
            item.val  = {24'd0, b};
            have_item = 1'b1;
            add_bytes(1);
            remain = remain - 32'd1;
            if (remain == 32'd0) begin
                ps = (pidx >= exp_cnt) ? PS_DONE : PS_LEN;
            end
        end
        if (lb) begin
            trunc       = (ps == PS_PAYLOAD);
            summ.kind   = KIND_SUMMARY;
            summ.nread  = pidx;
            summ.nbytes = nconsumed;
            summ.ok     = (pidx == exp_cnt) && (exp_cnt == 8'd0 || !trunc);
            summ.lst    = 1'b1;
            if (have_item) begin
                result_q.push_back(item);
            end
            result_q.push_back(summ);
            restart_parse();
        end else if (have_item) begin
            item.lst = 1'b1;
            result_q.push_back(item);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (quiet || r < 10) begin
            return 0;
        end else if (r < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Offer one byte; where chk is set the summary it closes is taken as typed
    task automatic send_byte(input logic [7:0] d, input logic lb, input logic chk,
                             input logic [7:0] nread, input logic [15:0] nbytes,
                             input logic ok_bit);
        int gap;
        t_result summ;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tlast  <= lb;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        parse_byte(d, lb);
        items_sent++;
        if (lb) begin
            buffers_sent++;
        end
        if (chk) begin
            summ        = result_q.pop_back();
            summ.nread  = nread;
            summ.nbytes = nbytes;
            summ.ok     = ok_bit;
            result_q.push_back(summ);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [7:0] v);
        i_s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (sel == REG_EXPECTED_COUNT) begin
            exp_cnt = v;
        end else if (sel == REG_BIG_ENDIAN) begin
            big_end = v[0];
        end
        reg_writes++;
    endtask

    task automatic send_queued(input int count);
        logic [8:0] e;
        repeat (count) begin
            e = pending_q.pop_front();
            send_byte(e[7:0], e[8], 1'b0, '0, '0, 1'b0);
        end
    endtask

    task automatic push_word(input logic [31:0] w);
        if (big_end) begin
            pending_q.push_back({1'b0, w[31:24]});
            pending_q.push_back({1'b0, w[23:16]});
            pending_q.push_back({1'b0, w[15:8]});
            pending_q.push_back({1'b0, w[7:0]});
        end else begin
            pending_q.push_back({1'b0, w[7:0]});
            pending_q.push_back({1'b0, w[15:8]});
            pending_q.push_back({1'b0, w[23:16]});
            pending_q.push_back({1'b0, w[31:24]});
        end
    endtask

    task automatic push_rand(input int n);
        repeat (n) pending_q.push_back({1'b0, 8'($urandom_range(0, 255))});
    endtask

    // Build one buffer: well formed, truncated, wrong count, or plain noise
    task automatic make_buffer();
        int sel;
        int ln;
        int cut;
        logic [31:0] cw;
        logic [8:0]  e;
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
            push_word({24'd0, exp_cnt});
            for (int i = 0; i < int'(exp_cnt); i++) begin
                ln = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 4);
                if (sel >= 65 && i == int'(exp_cnt) - 1 && $urandom_range(0, 1) == 1) begin
                    push_word($urandom);
                    push_rand($urandom_range(0, 6));
                end else begin
                    push_word(32'(ln));
                    push_rand(ln);
                end
            end
            if (sel < 65) begin
                if ($urandom_range(0, 3) == 0) begin
                    push_rand($urandom_range(1, 3));
                end
            end else begin
                cut = $urandom_range(1, pending_q.size());
                while (pending_q.size() > cut) e = pending_q.pop_back();
            end
        end else if (sel < 90) begin
            if ($urandom_range(0, 1) == 1) begin
                cw = {24'd0, exp_cnt} + 32'($urandom_range(1, 3));
            end else begin
                cw = $urandom;
            end
            if (cw == {24'd0, exp_cnt}) begin
                cw = cw ^ 32'h100;
            end
            push_word(cw);
            push_rand($urandom_range(0, 5));
        end else begin
            push_rand($urandom_range(1, 10));
        end
        e = pending_q.pop_back();
        pending_q.push_back({1'b1, e[7:0]});
    endtask

    function automatic t_step step_byte(input logic [7:0] d, input logic lb);
        t_step s;
        s      = '0;
        s.data = d;
        s.last = lb;
        return s;
    endfunction

    function automatic t_step step_end(input logic [7:0] d, input logic [7:0] nread,
                                       input logic [15:0] nbytes, input logic ok_bit);
        t_step s;
        s        = '0;
        s.data   = d;
        s.last   = 1'b1;
        s.chk    = 1'b1;
        s.nread  = nread;
        s.nbytes = nbytes;
        s.ok     = ok_bit;
        return s;
    endfunction

    function automatic t_step step_cfg(input logic [CFG_IDX_W-1:0] sel, input logic [7:0] v);
        t_step s;
        s         = '0;
        s.is_cfg  = 1'b1;
        s.reg_sel = sel;
        s.data    = v;
        return s;
    endfunction

    // Receiver: runs of ready, short and long stalls, one long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (quiet || $urandom_range(0, 1) == 1) begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b0;
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(15, 60)) @(posedge i_clk);
                end else begin
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end
            end
        end
    end

    task automatic cmp_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (result_q.size() == 0) begin
                $error("unexpected result: kind %0d tdata 0x%0h", o_m_tuser, o_m_tdata);
                n_errors++;
            end else begin
                want = result_q.pop_front();
                cmp_field("kind", 32'(want.kind), 32'(o_m_tuser));
                cmp_field("param_index", 32'(want.idx), 32'(o_m_tdata[7:0]));
                cmp_field("value", want.val, o_m_tdata[39:8]);
                cmp_field("params_read", 32'(want.nread), 32'(o_m_tdata[47:40]));
                cmp_field("consumed_bytes", 32'(want.nbytes), 32'(o_m_tdata[63:48]));
                cmp_field("ok", 32'(want.ok), 32'(o_m_tdata[64]));
                cmp_field("tdata padding", 32'd0, 32'(o_m_tdata[71:65]));
                cmp_field("last_result", 32'(want.lst), 32'(o_m_tlast));
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int  split;
        logic [7:0] ec;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // count zero with zero expected, then trailing byte
        steps.push_back(step_byte(8'h00, 1'b0));
        steps.push_back(step_byte(8'h00, 1'b0));
        steps.push_back(step_byte(8'h00, 1'b0));
        steps.push_back(step_byte(8'h00, 1'b0));
        steps.push_back(step_end(8'hFF, 8'd0, 16'd4, 1'b1));
        // lone byte: partial count word
        steps.push_back(step_end(8'h07, 8'd0, 16'd0, 1'b1));
        // count mismatch at the register extremes
        steps.push_back(step_cfg(REG_EXPECTED_COUNT, 8'd255));
        steps.push_back(step_cfg(REG_BIG_ENDIAN, 8'd1));
        steps.push_back(step_byte(8'hFF, 1'b0));
        steps.push_back(step_byte(8'hFF, 1'b0));
        steps.push_back(step_byte(8'hFF, 1'b0));
        steps.push_back(step_end(8'hFF, 8'd0, 16'd0, 1'b0));
        // two parameters: zero length, then one cut short by the buffer end
        steps.push_back(step_cfg(REG_EXPECTED_COUNT, 8'd2));
        steps.push_back(step_byte(8'h00, 1'b0));
        steps.push_back(step_byte(8'h00, 1'b0));
        steps.push_back(step_byte(8'h00, 1'b0));
        steps.push_back(step_byte(8'h02, 1'b0));
        steps.push_back(step_byte(8'h00, 1'b0));
        steps.push_back(step_byte(8'h00, 1'b0));
        steps.push_back(step_byte(8'h00, 1'b0));
        steps.push_back(step_byte(8'h00, 1'b0));
        steps.push_back(step_byte(8'h00, 1'b0));
        steps.push_back(step_byte(8'h00, 1'b0));
        steps.push_back(step_byte(8'h00, 1'b0));
        steps.push_back(step_byte(8'h03, 1'b0));
        steps.push_back(step_end(8'hAB, 8'd2, 16'd13, 1'b0));

        foreach (steps[i]) begin
            if (steps[i].is_cfg) begin
                write_reg(steps[i].reg_sel, steps[i].data);
            end else begin
                send_byte(steps[i].data, steps[i].last, steps[i].chk,
                          steps[i].nread, steps[i].nbytes, steps[i].ok);
            end
        end

        // one long payload back to back, cut short by the buffer end
        write_reg(REG_EXPECTED_COUNT, 8'd1);
        write_reg(REG_BIG_ENDIAN, 8'd0);
        quiet = 1'b1;
        push_word(32'd1);
        push_word(32'h0001_1000);
        send_queued(pending_q.size());
        for (int k = 0; k < LONG_PAYLOAD; k++) begin
            send_byte(8'($urandom_range(0, 255)), k == LONG_PAYLOAD - 1,
                      1'b0, '0, '0, 1'b0);
        end
        quiet = 1'b0;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case ($urandom_range(0, 9))
                0, 1: ec = 8'd0;
                8, 9: ec = 8'($urandom_range(4, 10));
                default: ec = 8'($urandom_range(1, 3));
            endcase
            write_reg(REG_EXPECTED_COUNT, ec);
            if (ph < 2 || $urandom_range(0, 1) == 1) begin
                write_reg(REG_BIG_ENDIAN, (ph < 2) ? 8'(ph) : 8'($urandom_range(0, 1)));
            end
            if (ph == 0) begin
                hold_off_req = 1'b1;
            end
            // finish a buffer left open across the register change
            send_queued(pending_q.size());
            split = items_sent;
            while (items_sent - split < PHASE_BYTES) begin
                make_buffer();
                if (items_sent - split + pending_q.size() >= PHASE_BYTES &&
                    ph != NUM_PHASES - 1 && pending_q.size() > 1 &&
                    $urandom_range(0, 2) == 0) begin
                    send_queued($urandom_range(1, pending_q.size() - 1));
                    break;
                end
                send_queued(pending_q.size());
            end
        end

        i_s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d bytes in %0d buffers with %0d register writes; %0d results checked.",
                 items_sent, buffers_sent, reg_writes, n_checked);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
